// File: rtl/hts_pkg.sv
// ----------------------------------------------------------------------------
// hts_pkg
// Shared types and constants for the hysteresis thermostat with trend plot.
// ----------------------------------------------------------------------------
package hts_pkg;

   localparam int SAMPLE_WIDTH    = 10;
   localparam int COLUMN_WIDTH    = 7;
   localparam int ROW_WIDTH       = 6;
   localparam int DIGIT_WIDTH     = 4;
   localparam int DEGREE_WIDTH    = 7;
   localparam int CSR_INDEX_WIDTH = 1;
   localparam int CSR_DATA_WIDTH  = 10;

   localparam int PLOT_COLUMNS_DEFAULT = 80;
   localparam int PLOT_ROWS_DEFAULT    = 60;

   localparam int PRODUCT_WIDTH = 24;
   localparam int FRAC_BITS     = 16;
   localparam int ROW_MULT      = 3780;
   localparam int DEGREE_MULT   = 6342;
   localparam int ROUND_HALF    = 32768;
   localparam int DEGREE_MAX    = 99;

   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_LOW_THRESHOLD  = 1'b0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_HIGH_THRESHOLD = 1'b1;

   typedef enum logic [1:0] {
      SYM_NONE  = 2'd0,
      SYM_FLAME = 2'd1,
      SYM_FLAKE = 2'd2
   } symbol_type;

   typedef struct packed {
      logic [ROW_WIDTH-1:0]   row;
      logic [DIGIT_WIDTH-1:0] tens;
      logic [DIGIT_WIDTH-1:0] ones;
   } scaled_type;

endpackage

// File: rtl/hts_scale.sv
// ----------------------------------------------------------------------------
// hts_scale
// Fixed-point scaling of one sample to a plot row and to decimal degrees.
// ----------------------------------------------------------------------------
module hts_scale
   import hts_pkg::*;
#(
   parameter int PLOT_ROWS = PLOT_ROWS_DEFAULT
) (
   input  logic [SAMPLE_WIDTH-1:0] sample,
   output scaled_type              scaled
);

   logic [PRODUCT_WIDTH-1:0] row_product;
   logic [PRODUCT_WIDTH-1:0] degree_product;
   logic [7:0]               row_raw;
   logic [7:0]               degree_raw;
   logic [DEGREE_WIDTH-1:0]  degrees;
   logic [DIGIT_WIDTH-1:0]   tens;
   logic [DEGREE_WIDTH-1:0]  ones_wide;

   assign row_product = PRODUCT_WIDTH'(sample) * PRODUCT_WIDTH'(ROW_MULT)
                        + PRODUCT_WIDTH'(ROUND_HALF);
   assign degree_product = PRODUCT_WIDTH'(sample) * PRODUCT_WIDTH'(DEGREE_MULT)
                           + PRODUCT_WIDTH'(ROUND_HALF);
   assign row_raw    = row_product[FRAC_BITS+7:FRAC_BITS];
   assign degree_raw = degree_product[FRAC_BITS+7:FRAC_BITS];

   always_comb begin
      if (row_raw > 8'(PLOT_ROWS - 1)) begin
         scaled.row = ROW_WIDTH'(PLOT_ROWS - 1);
      end else begin
         scaled.row = row_raw[ROW_WIDTH-1:0];
      end
      if (degree_raw > 8'(DEGREE_MAX)) begin
         degrees = DEGREE_WIDTH'(DEGREE_MAX);
      end else begin
         degrees = degree_raw[DEGREE_WIDTH-1:0];
      end
      tens = '0;
      for (int i = 1; i < 10; i++) begin
         if (degrees >= DEGREE_WIDTH'(i * 10)) begin
            tens = DIGIT_WIDTH'(i);
         end
      end
      ones_wide   = degrees - DEGREE_WIDTH'(tens) * DEGREE_WIDTH'(10);
      scaled.tens = tens;
      scaled.ones = ones_wide[DIGIT_WIDTH-1:0];
   end

endmodule

// File: rtl/hysteresis_thermostat_with_plot_top.sv
// ----------------------------------------------------------------------------
// hysteresis_thermostat_with_plot_top
// Bang-bang thermostat with hysteresis, symbol events and a trend plot.
// ----------------------------------------------------------------------------
// Each accepted sample word yields one result word: the sample sits in the
// input register while the threshold, plot and scaling logic works on it, and
// the result register loads once the result side is free. A new sample can
// be accepted every cycle while results are taken, and one more while a
// finished result waits on rsp_ready. The user must write threshold registers
// through the csr port only while idle; the block itself does not enforce it.
module hysteresis_thermostat_with_plot_top
   import hts_pkg::*;
#(
   parameter int PLOT_COLUMNS = PLOT_COLUMNS_DEFAULT,
   parameter int PLOT_ROWS    = PLOT_ROWS_DEFAULT
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  logic [SAMPLE_WIDTH-1:0]    req_sample,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output logic                       rsp_heater_on,
   output logic                       rsp_show_flame,
   output logic                       rsp_show_flake,
   output logic                       rsp_point_valid,
   output logic [COLUMN_WIDTH-1:0]    rsp_point_column,
   output logic [ROW_WIDTH-1:0]       rsp_point_row,
   output logic                       rsp_plot_full,
   output logic [DIGIT_WIDTH-1:0]     rsp_degree_tens,
   output logic [DIGIT_WIDTH-1:0]     rsp_degree_ones,
   input  logic                       csr_write_enable,
   input  logic [CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [CSR_DATA_WIDTH-1:0]  csr_write_data
);

   logic [SAMPLE_WIDTH-1:0] low_threshold_ff;
   logic [SAMPLE_WIDTH-1:0] high_threshold_ff;
   logic                    in_valid_ff;
   logic [SAMPLE_WIDTH-1:0] in_sample_ff;
   logic                    heater_ff, heater_in;
   symbol_type              symbol_ff, symbol_in, symbol_mid;
   logic [COLUMN_WIDTH-1:0] count_ff, count_in;
   logic [ROW_WIDTH-1:0]    prev_row_ff, prev_row_in;
   logic                    out_valid_ff;
   logic                    heater_out_ff;
   logic                    flame_ff, flame_in;
   logic                    flake_ff, flake_in;
   logic                    point_valid_ff, point_valid_in;
   logic [COLUMN_WIDTH-1:0] column_ff, column_in;
   logic [ROW_WIDTH-1:0]    row_ff, row_in;
   logic                    full_ff, full_in;
   logic [DIGIT_WIDTH-1:0]  tens_ff, ones_ff;
   logic                    out_free;
   logic                    advance;
   logic                    at_low, at_high;
   scaled_type              scaled;

   hts_scale #(
      .PLOT_ROWS(PLOT_ROWS)
   ) u_scale (
      .sample(in_sample_ff),
      .scaled(scaled)
   );

   assign out_free  = !out_valid_ff || rsp_ready;
   assign advance   = in_valid_ff && out_free;
   assign req_ready = !in_valid_ff || out_free;

   assign at_low  = in_sample_ff <= low_threshold_ff;
   assign at_high = in_sample_ff >= high_threshold_ff;

   always_comb begin
      point_valid_in = count_ff < COLUMN_WIDTH'(PLOT_COLUMNS);
      column_in      = '0;
      row_in         = '0;
      count_in       = count_ff;
      prev_row_in    = prev_row_ff;
      if (point_valid_in) begin
         column_in   = count_ff;
         row_in      = prev_row_ff;
         count_in    = count_ff + COLUMN_WIDTH'(1);
         prev_row_in = scaled.row;
      end
      full_in = count_in >= COLUMN_WIDTH'(PLOT_COLUMNS);

      heater_in  = heater_ff;
      symbol_mid = symbol_ff;
      flame_in   = 1'b0;
      flake_in   = 1'b0;
      if (at_low) begin
         heater_in  = 1'b1;
         flame_in   = symbol_ff != SYM_FLAME;
         symbol_mid = SYM_FLAME;
      end
      symbol_in = symbol_mid;
      if (at_high) begin
         heater_in = 1'b0;
         flake_in  = symbol_mid != SYM_FLAKE;
         symbol_in = SYM_FLAKE;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         low_threshold_ff  <= '0;
         high_threshold_ff <= '0;
      end else if (csr_write_enable) begin
         case (csr_index)
            CSR_LOW_THRESHOLD:  low_threshold_ff  <= csr_write_data;
            CSR_HIGH_THRESHOLD: high_threshold_ff <= csr_write_data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_ready) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_ready && req_valid) begin
         in_sample_ff <= req_sample;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         heater_ff    <= 1'b0;
         symbol_ff    <= SYM_NONE;
         count_ff     <= '0;
         prev_row_ff  <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         if (out_free) begin
            out_valid_ff <= in_valid_ff;
         end
         if (advance) begin
            heater_ff   <= heater_in;
            symbol_ff   <= symbol_in;
            count_ff    <= count_in;
            prev_row_ff <= prev_row_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         heater_out_ff  <= heater_in;
         flame_ff       <= flame_in;
         flake_ff       <= flake_in;
         point_valid_ff <= point_valid_in;
         column_ff      <= column_in;
         row_ff         <= row_in;
         full_ff        <= full_in;
         tens_ff        <= scaled.tens;
         ones_ff        <= scaled.ones;
      end
   end

   assign rsp_valid        = out_valid_ff;
   assign rsp_heater_on    = heater_out_ff;
   assign rsp_show_flame   = flame_ff;
   assign rsp_show_flake   = flake_ff;
   assign rsp_point_valid  = point_valid_ff;
   assign rsp_point_column = column_ff;
   assign rsp_point_row    = row_ff;
   assign rsp_plot_full    = full_ff;
   assign rsp_degree_tens  = tens_ff;
   assign rsp_degree_ones  = ones_ff;

endmodule

// File: bench/hysteresis_thermostat_with_plot_top_tb.sv
// ----------------------------------------------------------------------------
// hysteresis_thermostat_with_plot_top_tb
// Drives temperature sample words through the thermostat under several
// threshold settings, with random gaps on the sample side and random stalls on
// the result side. An in-bench copy of the heater, symbol, plot and degree
// logic predicts every result word, and each one is compared field by field.
// ----------------------------------------------------------------------------
module hysteresis_thermostat_with_plot_top_tb
   import hts_pkg::*;
();

   timeunit 1ns;
   timeprecision 1ps;

   localparam int CYCLE_LIMIT  = 400000;
   localparam int PHASE_ITEMS  = 230;
   localparam int PRINT_LIMIT  = 40;
   localparam int SAMPLE_MAX   = (1 << SAMPLE_WIDTH) - 1;

   typedef struct packed {
      logic                    heater_on;
      logic                    show_flame;
      logic                    show_flake;
      logic                    point_valid;
      logic [COLUMN_WIDTH-1:0] point_column;
      logic [ROW_WIDTH-1:0]    point_row;
      logic                    plot_full;
      logic [DIGIT_WIDTH-1:0]  degree_tens;
      logic [DIGIT_WIDTH-1:0]  degree_ones;
   } readout_type;

   class thermostat_shadow;
      int          low_threshold;
      int          high_threshold;
      logic        heater;
      symbol_type  shown;
      int          column_count;
      int          previous_row;
      readout_type due_readouts[$];
      int          bad_fields;

      function new();
         low_threshold  = 0;
         high_threshold = 0;
         heater         = 1'b0;
         shown          = SYM_NONE;
         column_count   = 0;
         previous_row   = 0;
         bad_fields     = 0;
      endfunction

      function int pending();
         return due_readouts.size();
      endfunction

      function void take_sample(logic [SAMPLE_WIDTH-1:0] sample);
         readout_type word;
         int          row;
         int          degrees;
         word = '0;
         if (column_count < PLOT_COLUMNS_DEFAULT) begin
            word.point_valid  = 1'b1;
            word.point_column = column_count[COLUMN_WIDTH-1:0];
            word.point_row    = previous_row[ROW_WIDTH-1:0];
            row = (int'(sample) * ROW_MULT + ROUND_HALF) >> FRAC_BITS;
            previous_row = (row > PLOT_ROWS_DEFAULT - 1) ? PLOT_ROWS_DEFAULT - 1 : row;
            column_count++;
         end
         word.plot_full = (column_count >= PLOT_COLUMNS_DEFAULT);
         if (int'(sample) <= low_threshold) begin
            heater = 1'b1;
            if (shown != SYM_FLAME) begin
               word.show_flame = 1'b1;
               shown = SYM_FLAME;
            end
         end
         if (int'(sample) >= high_threshold) begin
            heater = 1'b0;
            if (shown != SYM_FLAKE) begin
               word.show_flake = 1'b1;
               shown = SYM_FLAKE;
            end
         end
         degrees = (int'(sample) * DEGREE_MULT + ROUND_HALF) >> FRAC_BITS;
         if (degrees > DEGREE_MAX) begin
            degrees = DEGREE_MAX;
         end
         word.heater_on   = heater;
         word.degree_tens = DIGIT_WIDTH'(degrees / 10);
         word.degree_ones = DIGIT_WIDTH'(degrees % 10);
         due_readouts.push_back(word);
      endfunction

      task report(string msg);
         if (bad_fields < PRINT_LIMIT) begin
            $display("%0t ns: %s", $realtime, msg);
         end
         bad_fields++;
      endtask

      task compare_field(string name, int got, int want);
         if (got != want) begin
            report($sformatf("%s is %0d, predicted %0d", name, got, want));
         end
      endtask

      task match_readout(readout_type got);
         readout_type want;
         if (due_readouts.size() == 0) begin
            report("result word arrived with no sample word outstanding");
         end else begin
            want = due_readouts.pop_front();
            compare_field("heater_on", got.heater_on, want.heater_on);
            compare_field("show_flame", got.show_flame, want.show_flame);
            compare_field("show_flake", got.show_flake, want.show_flake);
            compare_field("point_valid", got.point_valid, want.point_valid);
            compare_field("point_column", got.point_column, want.point_column);
            compare_field("point_row", got.point_row, want.point_row);
            compare_field("plot_full", got.plot_full, want.plot_full);
            compare_field("degree_tens", got.degree_tens, want.degree_tens);
            compare_field("degree_ones", got.degree_ones, want.degree_ones);
         end
      endtask
   endclass

   logic                       clock            = 1'b0;
   logic                       reset            = 1'b1;
   logic                       req_valid        = 1'b0;
   logic                       req_ready;
   logic [SAMPLE_WIDTH-1:0]    req_sample       = '0;
   logic                       rsp_valid;
   logic                       rsp_ready        = 1'b0;
   logic                       rsp_heater_on;
   logic                       rsp_show_flame;
   logic                       rsp_show_flake;
   logic                       rsp_point_valid;
   logic [COLUMN_WIDTH-1:0]    rsp_point_column;
   logic [ROW_WIDTH-1:0]       rsp_point_row;
   logic                       rsp_plot_full;
   logic [DIGIT_WIDTH-1:0]     rsp_degree_tens;
   logic [DIGIT_WIDTH-1:0]     rsp_degree_ones;
   logic                       csr_write_enable = 1'b0;
   logic [CSR_INDEX_WIDTH-1:0] csr_index        = CSR_LOW_THRESHOLD;
   logic [CSR_DATA_WIDTH-1:0]  csr_write_data   = '0;

   thermostat_shadow board;
   bit               idle_on = 1'b1;
   int               cycle_count = 0;

   hysteresis_thermostat_with_plot_top dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_sample       (req_sample),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_heater_on    (rsp_heater_on),
      .rsp_show_flame   (rsp_show_flame),
      .rsp_show_flake   (rsp_show_flake),
      .rsp_point_valid  (rsp_point_valid),
      .rsp_point_column (rsp_point_column),
      .rsp_point_row    (rsp_point_row),
      .rsp_plot_full    (rsp_plot_full),
      .rsp_degree_tens  (rsp_degree_tens),
      .rsp_degree_ones  (rsp_degree_ones),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("CHECK FAILED");
         $finish;
      end
   end

   task send_sample(input int sample);
      int gap;
      gap = idle_on ? $urandom_range(0, 15) : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid  <= 1'b1;
      req_sample <= SAMPLE_WIDTH'(sample);
      do @(posedge clock); while (!req_ready);
      board.take_sample(SAMPLE_WIDTH'(sample));
   endtask

   task drain();
      req_valid <= 1'b0;
      while (board.pending() > 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task set_thresholds(input int low, input int high);
      csr_write_enable <= 1'b1;
      csr_index        <= CSR_LOW_THRESHOLD;
      csr_write_data   <= CSR_DATA_WIDTH'(low);
      @(posedge clock);
      csr_index        <= CSR_HIGH_THRESHOLD;
      csr_write_data   <= CSR_DATA_WIDTH'(high);
      @(posedge clock);
      csr_write_enable <= 1'b0;
      board.low_threshold  = low;
      board.high_threshold = high;
   endtask

   function automatic int near_value(int center);
      int value;
      value = center + $urandom_range(0, 4) - 2;
      if (value < 0) begin
         value = 0;
      end else if (value > SAMPLE_MAX) begin
         value = SAMPLE_MAX;
      end
      return value;
   endfunction

   function automatic int pick_sample(int low, int high);
      int choice;
      choice = $urandom_range(0, 9);
      if (choice < 4) begin
         return $urandom_range(0, SAMPLE_MAX);
      end else if (choice < 6) begin
         return near_value(low);
      end else if (choice < 8) begin
         return near_value(high);
      end else if (choice == 8) begin
         return 0;
      end
      return SAMPLE_MAX;
   endfunction

   task run_phase(input int low, input int high);
      drain();
      set_thresholds(low, high);
      for (int i = 0; i < PHASE_ITEMS; i++) begin
         send_sample(pick_sample(low, high));
      end
   endtask

   initial begin
      readout_type got;
      int          stall;
      wait (reset == 1'b0);
      forever begin
         stall = idle_on ? $urandom_range(0, 15) : 0;
         if (stall > 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!rsp_valid);
         got.heater_on    = rsp_heater_on;
         got.show_flame   = rsp_show_flame;
         got.show_flake   = rsp_show_flake;
         got.point_valid  = rsp_point_valid;
         got.point_column = rsp_point_column;
         got.point_row    = rsp_point_row;
         got.plot_full    = rsp_plot_full;
         got.degree_tens  = rsp_degree_tens;
         got.degree_ones  = rsp_degree_ones;
         board.match_readout(got);
      end
   end

   initial begin
      int low;
      int high;
      board = new();
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Reset thresholds are both zero, so every sample meets the high one and only zero meets the low one.
      send_sample(0);
      send_sample(SAMPLE_MAX);
      send_sample(5);

      drain();
      set_thresholds(300, 700);
      send_sample(300);
      send_sample(301);
      send_sample(699);
      send_sample(700);
      send_sample(SAMPLE_MAX);
      send_sample(0);
      send_sample(512);
      send_sample(SAMPLE_MAX);

      // Overlapping thresholds: samples between them meet both tests.
      drain();
      set_thresholds(600, 400);
      send_sample(500);
      send_sample(500);
      send_sample(0);
      send_sample(500);

      drain();
      set_thresholds(SAMPLE_MAX, SAMPLE_MAX);
      send_sample(SAMPLE_MAX);
      send_sample(0);
      send_sample(SAMPLE_MAX - 1);

      for (int phase = 0; phase < 8; phase++) begin
         idle_on = (phase % 3 != 2);
         case (phase)
            0: begin low = 0; high = SAMPLE_MAX; end
            1: begin low = SAMPLE_MAX; high = 0; end
            3: begin low = 0; high = 0; end
            5: begin low = SAMPLE_MAX; high = SAMPLE_MAX; end
            7: begin
               high = $urandom_range(0, SAMPLE_MAX - 1);
               low  = $urandom_range(high + 1, SAMPLE_MAX);
            end
            default: begin
               low  = $urandom_range(0, SAMPLE_MAX - 1);
               high = $urandom_range(low + 1, SAMPLE_MAX);
            end
         endcase
         run_phase(low, high);
      end

      drain();
      repeat (8) @(posedge clock);
      if (board.bad_fields == 0 && board.pending() == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule
